[rtl/cerq_pkg.sv]
// Shared constants and types for the coalescing event ring queue.
`timescale 1ns / 1ps

package cerq_pkg;

    localparam int DEPTH_DEF       = 16;
    localparam int VALUE_WIDTH_DEF = 16;

    localparam int CMD_W      = 8;
    localparam int IDX_W      = 8;
    localparam int EV_VALUE_W = 16;
    localparam int FILL_W     = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_CMD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_CMD  = 1'b1;

    localparam logic [CMD_W-1:0] MOTOR_CMD_RESET = 8'd0;
    localparam logic [CMD_W-1:0] AXIS_CMD_RESET  = 8'd1;

    localparam logic REQ_ENQUEUE = 1'b0;
    localparam logic REQ_DEQUEUE = 1'b1;

    // Control broadcast to every cell of the chain.
    typedef struct packed {
        logic shift;    // take the entry of the next cell toward the tail
        logic scan;     // move the search token one cell toward the tail
        logic merge;    // the cell holding a matching token takes the new value
        logic tok_clr;  // drop the search token
    } cell_ctrl_t;

endpackage

[rtl/coalescing_event_ring_queue.sv]
// Top level: command interface, request sequencer and the chain of queue cells.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low; its result appears on
// the result ports for exactly one cycle with done high, and the receiver cannot
// stall it, so capture it in that cycle. The queue is a chain of DEPTH cells with
// the oldest event in the first cell. For a dequeue, a plain enqueue, or an
// enqueue into an empty queue, done rises in the cycle after start. An enqueue
// of a motor or axis command walks a search token down the chain, one queued
// entry per cycle, and stops at the first entry with the same command and index;
// it visits at most the current fill of entries, so at most DEPTH. The next
// request may start in the cycle in which done is high. Configuration writes
// are taken at once and belong to idle periods.
module coalescing_event_ring_queue #(
    parameter int DEPTH       = cerq_pkg::DEPTH_DEF,
    parameter int VALUE_WIDTH = cerq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [cerq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cerq_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 req_type,
    input  logic [cerq_pkg::CMD_W-1:0]           ev_command,
    input  logic [cerq_pkg::IDX_W-1:0]           ev_index,
    input  logic signed [cerq_pkg::EV_VALUE_W-1:0] ev_value,
    output logic                                 done,
    output logic                                 ok,
    output logic                                 merged,
    output logic                                 dropped_oldest,
    output logic [cerq_pkg::CMD_W-1:0]           out_command,
    output logic [cerq_pkg::IDX_W-1:0]           out_index,
    output logic signed [cerq_pkg::EV_VALUE_W-1:0] out_value,
    output logic [cerq_pkg::FILL_W-1:0]          fill_count
);

    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int STEP_W = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_SCAN = 2'b10
    } state_t;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg, count_next;
    logic [STEP_W-1:0] step_reg, step_next;

    logic [cerq_pkg::CMD_W-1:0] motor_cmd_reg;
    logic [cerq_pkg::CMD_W-1:0] axis_cmd_reg;

    logic [cerq_pkg::CMD_W-1:0]    key_command_reg;
    logic [cerq_pkg::IDX_W-1:0]    key_index_reg;
    logic signed [VALUE_WIDTH-1:0] key_value_reg;

    logic [cerq_pkg::CMD_W-1:0]    key_command;
    logic [cerq_pkg::IDX_W-1:0]    key_index;
    logic signed [VALUE_WIDTH-1:0] key_value;
    logic signed [VALUE_WIDTH-1:0] ev_value_ext;

    logic                          done_reg, done_next;
    logic                          ok_reg, ok_next;
    logic                          merged_reg, merged_next;
    logic                          dropped_reg, dropped_next;
    logic [cerq_pkg::CMD_W-1:0]    out_command_reg, out_command_next;
    logic [cerq_pkg::IDX_W-1:0]    out_index_reg, out_index_next;
    logic signed [cerq_pkg::EV_VALUE_W-1:0] out_value_reg, out_value_next;

    cerq_pkg::cell_ctrl_t ctrl;
    logic [DEPTH-1:0]     load;
    logic [DEPTH-1:0]     tok_chain;
    logic [DEPTH-1:0]     hit;
    logic                 tok_start;
    logic                 accept;
    logic                 coalescible;
    logic                 full;
    logic                 append;

    logic [cerq_pkg::CMD_W-1:0]    cell_command [DEPTH];
    logic [cerq_pkg::IDX_W-1:0]    cell_index   [DEPTH];
    logic signed [VALUE_WIDTH-1:0] cell_value   [DEPTH];

    assign accept       = start && (state_reg == ST_IDLE);
    assign coalescible  = (ev_command == motor_cmd_reg) || (ev_command == axis_cmd_reg);
    assign full         = (count_reg == FULL_COUNT);
    assign ev_value_ext = VALUE_WIDTH'(ev_value);

    // Loads come straight from the request in the accept cycle, from the held key later.
    assign key_command = (state_reg == ST_SCAN) ? key_command_reg : ev_command;
    assign key_index   = (state_reg == ST_SCAN) ? key_index_reg   : ev_index;
    assign key_value   = (state_reg == ST_SCAN) ? key_value_reg   : ev_value_ext;

    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        step_next        = step_reg;
        ctrl             = '0;
        tok_start        = 1'b0;
        append           = 1'b0;
        done_next        = 1'b0;
        ok_next          = ok_reg;
        merged_next      = merged_reg;
        dropped_next     = dropped_reg;
        out_command_next = out_command_reg;
        out_index_next   = out_index_reg;
        out_value_next   = out_value_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req_type == cerq_pkg::REQ_DEQUEUE)
                    begin
                        done_next        = 1'b1;
                        merged_next      = 1'b0;
                        dropped_next     = 1'b0;
                        ok_next          = (count_reg != '0);
                        out_command_next = '0;
                        out_index_next   = '0;
                        out_value_next   = '0;
                        if (count_reg != '0)
                        begin
                            out_command_next = cell_command[0];
                            out_index_next   = cell_index[0];
                            out_value_next   = cerq_pkg::EV_VALUE_W'(cell_value[0]);
                            ctrl.shift       = 1'b1;
                            count_next       = count_reg - CNT_W'(1);
                        end
                    end
                    else if (coalescible && (count_reg != '0))
                    begin
                        // Start the search token at the oldest entry.
                        tok_start  = 1'b1;
                        ctrl.scan  = 1'b1;
                        step_next  = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        append = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (hit != '0)
                begin
                    ctrl.merge       = 1'b1;
                    ctrl.tok_clr     = 1'b1;
                    done_next        = 1'b1;
                    ok_next          = 1'b1;
                    merged_next      = 1'b1;
                    dropped_next     = 1'b0;
                    out_command_next = '0;
                    out_index_next   = '0;
                    out_value_next   = '0;
                    state_next       = ST_IDLE;
                end
                else if (CNT_W'(step_reg) == count_reg - CNT_W'(1))
                begin
                    ctrl.tok_clr = 1'b1;
                    append       = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    ctrl.scan = 1'b1;
                    step_next = step_reg + STEP_W'(1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (append)
        begin
            done_next        = 1'b1;
            ok_next          = 1'b1;
            merged_next      = 1'b0;
            dropped_next     = full;
            out_command_next = '0;
            out_index_next   = '0;
            out_value_next   = '0;
            if (full)
            begin
                // Drop the oldest: shift the chain, the last cell takes the new event.
                ctrl.shift = 1'b1;
            end
            else
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            load[i] = append && !full && (count_reg == CNT_W'(i));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            step_reg      <= '0;
            done_reg      <= 1'b0;
            motor_cmd_reg <= cerq_pkg::MOTOR_CMD_RESET;
            axis_cmd_reg  <= cerq_pkg::AXIS_CMD_RESET;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    cerq_pkg::REG_MOTOR_CMD: motor_cmd_reg <= cfg_data;
                    cerq_pkg::REG_AXIS_CMD:  axis_cmd_reg  <= cfg_data;
                    default:                 motor_cmd_reg <= motor_cmd_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg          <= ok_next;
        merged_reg      <= merged_next;
        dropped_reg     <= dropped_next;
        out_command_reg <= out_command_next;
        out_index_reg   <= out_index_next;
        out_value_reg   <= out_value_next;
        if (accept)
        begin
            key_command_reg <= ev_command;
            key_index_reg   <= ev_index;
            key_value_reg   <= ev_value_ext;
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [cerq_pkg::CMD_W-1:0]    nbr_command;
        logic [cerq_pkg::IDX_W-1:0]    nbr_index;
        logic signed [VALUE_WIDTH-1:0] nbr_value;
        logic                          tok_in;

        if (i == DEPTH - 1)
        begin : g_last
            assign nbr_command = key_command;
            assign nbr_index   = key_index;
            assign nbr_value   = key_value;
        end
        else
        begin : g_mid
            assign nbr_command = cell_command[i+1];
            assign nbr_index   = cell_index[i+1];
            assign nbr_value   = cell_value[i+1];
        end

        if (i == 0)
        begin : g_first
            assign tok_in = tok_start;
        end
        else
        begin : g_rest
            assign tok_in = tok_chain[i-1];
        end

        cerq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .load        (load[i]),
            .tok_in      (tok_in),
            .key_command (key_command),
            .key_index   (key_index),
            .key_value   (key_value),
            .nbr_command (nbr_command),
            .nbr_index   (nbr_index),
            .nbr_value   (nbr_value),
            .command     (cell_command[i]),
            .index       (cell_index[i]),
            .value       (cell_value[i]),
            .tok_out     (tok_chain[i]),
            .hit         (hit[i])
        );
    end

    assign busy           = (state_reg != ST_IDLE);
    assign done           = done_reg;
    assign ok             = ok_reg;
    assign merged         = merged_reg;
    assign dropped_oldest = dropped_reg;
    assign out_command    = out_command_reg;
    assign out_index      = out_index_reg;
    assign out_value      = out_value_reg;
    assign fill_count     = cerq_pkg::FILL_W'(count_reg);

endmodule

[rtl/cerq_cell.sv]
// One queue slot of the cell chain: entry storage, neighbor shift and token compare.
`timescale 1ns / 1ps

module cerq_cell #(
    parameter int VALUE_WIDTH = cerq_pkg::VALUE_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  cerq_pkg::cell_ctrl_t               ctrl,
    input  logic                               load,
    input  logic                               tok_in,
    input  logic [cerq_pkg::CMD_W-1:0]         key_command,
    input  logic [cerq_pkg::IDX_W-1:0]         key_index,
    input  logic signed [VALUE_WIDTH-1:0]      key_value,
    input  logic [cerq_pkg::CMD_W-1:0]         nbr_command,
    input  logic [cerq_pkg::IDX_W-1:0]         nbr_index,
    input  logic signed [VALUE_WIDTH-1:0]      nbr_value,
    output logic [cerq_pkg::CMD_W-1:0]         command,
    output logic [cerq_pkg::IDX_W-1:0]         index,
    output logic signed [VALUE_WIDTH-1:0]      value,
    output logic                               tok_out,
    output logic                               hit
);

    logic [cerq_pkg::CMD_W-1:0]    command_reg;
    logic [cerq_pkg::IDX_W-1:0]    index_reg;
    logic signed [VALUE_WIDTH-1:0] value_reg;
    logic                          tok_reg;
    logic                          tok_next;

    assign hit = tok_reg && (command_reg == key_command) && (index_reg == key_index);

    always_comb
    begin
        if (ctrl.tok_clr)
        begin
            tok_next = 1'b0;
        end
        else if (ctrl.scan)
        begin
            tok_next = tok_in;
        end
        else
        begin
            tok_next = tok_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg <= 1'b0;
        end
        else
        begin
            tok_reg <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            command_reg <= key_command;
            index_reg   <= key_index;
            value_reg   <= key_value;
        end
        else if (ctrl.shift)
        begin
            command_reg <= nbr_command;
            index_reg   <= nbr_index;
            value_reg   <= nbr_value;
        end
        else if (ctrl.merge && hit)
        begin
            value_reg <= key_value;
        end
    end

    assign command = command_reg;
    assign index   = index_reg;
    assign value   = value_reg;
    assign tok_out = tok_reg;

endmodule

[tb/testbench.sv]
// Self-checking testbench for the coalescing event ring queue.
`timescale 1ns / 1ps

module testbench;
    import cerq_pkg::*;

    localparam int QDEPTH       = DEPTH_DEF;
    localparam int LIMIT_CYCLES = 200000;
    localparam int PHASE_ITEMS  = 150;

    typedef struct packed {
        logic                          req;
        logic [CMD_W-1:0]              cmd;
        logic [IDX_W-1:0]              idx;
        logic signed [EV_VALUE_W-1:0]  val;
    } event_request_t;

    typedef struct packed {
        logic                          ok;
        logic                          merged;
        logic                          dropped;
        logic [CMD_W-1:0]              cmd;
        logic [IDX_W-1:0]              idx;
        logic signed [EV_VALUE_W-1:0]  val;
        logic [FILL_W-1:0]             fill;
    } event_result_t;

    typedef struct packed {
        event_request_t request;
        logic           typed;
        event_result_t  want;
    } directed_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          cfg_we;
    logic [CFG_IDX_W-1:0]          cfg_index;
    logic [CFG_DATA_W-1:0]         cfg_data;
    logic                          start;
    logic                          busy;
    logic                          req_type;
    logic [CMD_W-1:0]              ev_command;
    logic [IDX_W-1:0]              ev_index;
    logic signed [EV_VALUE_W-1:0]  ev_value;
    logic                          done;
    logic                          ok;
    logic                          merged;
    logic                          dropped_oldest;
    logic [CMD_W-1:0]              out_command;
    logic [IDX_W-1:0]              out_index;
    logic signed [EV_VALUE_W-1:0]  out_value;
    logic [FILL_W-1:0]             fill_count;

    // Shadow copy of the queue and the coalescing codes
    logic [CMD_W-1:0]              shadow_cmd [QDEPTH];
    logic [IDX_W-1:0]              shadow_idx [QDEPTH];
    logic signed [EV_VALUE_W-1:0]  shadow_val [QDEPTH];
    int unsigned                   shadow_head;
    int unsigned                   shadow_tail;
    int unsigned                   shadow_fill;
    logic [CMD_W-1:0]              motor_code;
    logic [CMD_W-1:0]              axis_code;

    event_result_t                 pending_outcomes [$];
    directed_row_t                 directed_rows [$];

    int fail_count;
    int results_checked;
    int merges_seen;
    int drops_seen;
    int empty_dequeues;
    int cycle_count;

    coalescing_event_ring_queue dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .req_type       (req_type),
        .ev_command     (ev_command),
        .ev_index       (ev_index),
        .ev_value       (ev_value),
        .done           (done),
        .ok             (ok),
        .merged         (merged),
        .dropped_oldest (dropped_oldest),
        .out_command    (out_command),
        .out_index      (out_index),
        .out_value      (out_value),
        .fill_count     (fill_count)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #2 clk = ~clk;
        end
    end

    // Apply one accepted request to the shadow queue and return its outcome.
    function automatic event_result_t apply_to_shadow_queue(input event_request_t r);
        event_result_t res;
        int unsigned   slot;
        res = '0;
        if (r.req == REQ_ENQUEUE)
        begin
            res.ok = 1'b1;
            if (r.cmd == motor_code || r.cmd == axis_code)
            begin
                slot = shadow_head;
                for (int k = 0; k < shadow_fill; k++)
                begin
                    if (!res.merged && shadow_cmd[slot] == r.cmd && shadow_idx[slot] == r.idx)
                    begin
                        shadow_val[slot] = r.val;
                        res.merged = 1'b1;
                    end
                    slot = (slot + 1) % QDEPTH;
                end
            end
            if (!res.merged)
            begin
                shadow_cmd[shadow_tail] = r.cmd;
                shadow_idx[shadow_tail] = r.idx;
                shadow_val[shadow_tail] = r.val;
                shadow_tail = (shadow_tail + 1) % QDEPTH;
                if (shadow_fill == QDEPTH)
                begin
                    // overwrite the oldest entry
                    shadow_head = (shadow_head + 1) % QDEPTH;
                    res.dropped = 1'b1;
                end
                else
                begin
                    shadow_fill++;
                end
            end
        end
        else if (shadow_fill != 0)
        begin
            res.ok  = 1'b1;
            res.cmd = shadow_cmd[shadow_head];
            res.idx = shadow_idx[shadow_head];
            res.val = shadow_val[shadow_head];
            shadow_head = (shadow_head + 1) % QDEPTH;
            shadow_fill--;
        end
        res.fill = FILL_W'(shadow_fill);
        return res;
    endfunction

    function automatic event_request_t random_request(input int unsigned dequeue_pct);
        event_request_t r;
        int unsigned    pick;
        pick  = $urandom_range(9);
        r.req = ($urandom_range(99) < dequeue_pct) ? REQ_DEQUEUE : REQ_ENQUEUE;
        if (pick < 4)
            r.cmd = motor_code;
        else if (pick < 7)
            r.cmd = axis_code;
        else
            r.cmd = CMD_W'($urandom);
        // keep most indexes in a narrow set so merges happen often
        r.idx = ($urandom_range(3) != 0) ? IDX_W'($urandom_range(3)) : IDX_W'($urandom);
        r.val = EV_VALUE_W'($urandom);
        return r;
    endfunction

    function automatic void add_row(input event_request_t r, input logic typed,
                                    input event_result_t want);
        directed_rows.push_back(directed_row_t'{r, typed, want});
    endfunction

    function automatic void check_field(input string name, input logic signed [31:0] want_v,
                                        input logic signed [31:0] got_v);
        if (got_v !== want_v)
        begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            fail_count++;
        end
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input event_request_t r, input logic typed,
                                input event_result_t want);
        event_result_t predicted;
        bit            taken;
        start      <= 1'b1;
        req_type   <= r.req;
        ev_command <= r.cmd;
        ev_index   <= r.idx;
        ev_value   <= r.val;
        taken = 1'b0;
        while (!taken)
        begin
            @(posedge clk);
            taken = !busy;
        end
        predicted = apply_to_shadow_queue(r);
        pending_outcomes.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic idle_gap(input bit quiet);
        if (!quiet)
        begin
            while ($urandom_range(99) < 24)
            begin
                start <= 1'b0;
                @(negedge clk);
            end
        end
    endtask

    // Write both code registers while the block is idle.
    task automatic write_codes(input logic [CMD_W-1:0] motor, input logic [CMD_W-1:0] axis);
        start <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_MOTOR_CMD;
        cfg_data  <= motor;
        @(posedge clk);
        motor_code = motor;
        @(negedge clk);
        cfg_index <= REG_AXIS_CMD;
        cfg_data  <= axis;
        @(posedge clk);
        axis_code = axis;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    always @(posedge clk)
    begin : result_check
        event_result_t want;
        if (rst_n && done)
        begin
            if (pending_outcomes.size() == 0)
            begin
                $error("result with no request pending");
                fail_count++;
            end
            else
            begin
                want = pending_outcomes.pop_front();
                check_field("ok", want.ok, ok);
                check_field("merged", want.merged, merged);
                check_field("dropped_oldest", want.dropped, dropped_oldest);
                check_field("out_command", want.cmd, out_command);
                check_field("out_index", want.idx, out_index);
                check_field("out_value", want.val, out_value);
                check_field("fill_count", want.fill, fill_count);
                results_checked++;
                merges_seen    += want.merged;
                drops_seen     += want.dropped;
                empty_dequeues += !want.ok;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("coalescing_event_ring_queue regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [CMD_W-1:0] motor_setting [4];
        logic [CMD_W-1:0] axis_setting [4];
        int unsigned      dequeue_pct [4];
        event_result_t    none;

        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = REG_MOTOR_CMD;
        cfg_data    = '0;
        start       = 1'b0;
        req_type    = REQ_ENQUEUE;
        ev_command  = '0;
        ev_index    = '0;
        ev_value    = '0;
        fail_count      = 0;
        results_checked = 0;
        merges_seen     = 0;
        drops_seen      = 0;
        empty_dequeues  = 0;
        cycle_count     = 0;
        shadow_head = 0;
        shadow_tail = 0;
        shadow_fill = 0;
        motor_code  = MOTOR_CMD_RESET;
        axis_code   = AXIS_CMD_RESET;
        none        = '0;

        // Directed table; codes are at reset: motor 0, axis 1.
        add_row(event_request_t'{REQ_DEQUEUE, 8'h00, 8'h00, 16'sh0000}, 1'b1,
                event_result_t'{1'b0, 1'b0, 1'b0, 8'h00, 8'h00, 16'sh0000, 5'd0});
        add_row(event_request_t'{REQ_ENQUEUE, 8'hFF, 8'h00, 16'sh7FFF}, 1'b1,
                event_result_t'{1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 16'sh0000, 5'd1});
        add_row(event_request_t'{REQ_ENQUEUE, 8'h00, 8'hFF, 16'sh8000}, 1'b1,
                event_result_t'{1'b1, 1'b0, 1'b0, 8'h00, 8'h00, 16'sh0000, 5'd2});
        add_row(event_request_t'{REQ_ENQUEUE, 8'h00, 8'hFF, 16'sh0001}, 1'b1,
                event_result_t'{1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 16'sh0000, 5'd2});
        add_row(event_request_t'{REQ_ENQUEUE, 8'h01, 8'h00, 16'shFFFF}, 1'b0, none);
        add_row(event_request_t'{REQ_ENQUEUE, 8'h01, 8'h00, 16'sh0005}, 1'b0, none);
        // plain commands never merge
        add_row(event_request_t'{REQ_ENQUEUE, 8'h02, 8'h00, 16'sh0003}, 1'b0, none);
        add_row(event_request_t'{REQ_ENQUEUE, 8'h02, 8'h00, 16'sh0004}, 1'b0, none);
        add_row(event_request_t'{REQ_DEQUEUE, 8'hFF, 8'hFF, 16'shFFFF}, 1'b1,
                event_result_t'{1'b1, 1'b0, 1'b0, 8'hFF, 8'h00, 16'sh7FFF, 5'd4});
        add_row(event_request_t'{REQ_DEQUEUE, 8'h00, 8'h00, 16'sh0000}, 1'b1,
                event_result_t'{1'b1, 1'b0, 1'b0, 8'h00, 8'hFF, 16'sh0001, 5'd3});
        for (int k = 0; k < 12; k++)
            add_row(event_request_t'{REQ_ENQUEUE, 8'h03, IDX_W'(k * 21), 16'(k * 4369)},
                    1'b0, none);
        add_row(event_request_t'{REQ_ENQUEUE, 8'h00, 8'hAA, 16'sh1234}, 1'b0, none);
        add_row(event_request_t'{REQ_ENQUEUE, 8'h03, 8'h55, 16'shAAAA}, 1'b1,
                event_result_t'{1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 16'sh0000, 5'd16});
        // merge into a full queue: nothing is dropped
        add_row(event_request_t'{REQ_ENQUEUE, 8'h00, 8'hAA, 16'shFFFE}, 1'b1,
                event_result_t'{1'b1, 1'b1, 1'b0, 8'h00, 8'h00, 16'sh0000, 5'd16});
        add_row(event_request_t'{REQ_ENQUEUE, 8'h01, 8'h55, 16'sh0000}, 1'b1,
                event_result_t'{1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 16'sh0000, 5'd16});

        motor_setting = '{MOTOR_CMD_RESET, 8'hFF, 8'hFF, CMD_W'($urandom)};
        axis_setting  = '{AXIS_CMD_RESET, 8'hFF, 8'h00, CMD_W'($urandom)};
        dequeue_pct   = '{35, 25, 60, 45};

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            idle_gap(1'b0);
            send_request(directed_rows[i].request, directed_rows[i].typed,
                         directed_rows[i].want);
        end

        for (int ph = 0; ph < 4; ph++)
        begin
            write_codes(motor_setting[ph], axis_setting[ph]);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // first phase runs back to back
                idle_gap(ph == 0);
                send_request(random_request(dequeue_pct[ph]), 1'b0, none);
            end
        end
        start <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (QDEPTH + 4) @(posedge clk);

        $display("checked %0d results: %0d merges, %0d oldest-entry drops, %0d empty dequeues",
                 results_checked, merges_seen, drops_seen, empty_dequeues);
        $display("code settings: reset, both 255, 255/0 and one random pair");
        if (fail_count == 0)
            $display("coalescing_event_ring_queue regression: pass");
        else
            $display("coalescing_event_ring_queue regression: fail");
        $finish;
    end

endmodule
